[design/acwc_pkg.sv]
// acwc_pkg: shared types and constants of the ack congestion window controller
// no dependencies
package acwc_pkg;

    localparam int SEQ_BITS_DEF = 16;
    localparam int WIN_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int DIVD_W       = 33;
    localparam int DIVS_W       = 24;
    localparam int DIVC_W       = 6;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [19:0] USEC_MAX     = 20'd999999;
    localparam logic [11:0] SEC_MAX      = 12'd4095;

    localparam logic [3:0]  DUP_THR_RST  = 4'd3;
    localparam logic [15:0] GAIN_RST     = 16'd256;
    localparam logic [8:0]  WEIGHT_RST   = 9'd224;
    localparam logic [8:0]  WEIGHT_ONE   = 9'd256;
    localparam logic [15:0] WINDOW_RST   = 16'd2000;
    localparam logic [11:0] TO_SEC_RST   = 12'd1;
    localparam logic [19:0] TO_USEC_RST  = 20'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUP_THRESHOLD = 3'd0,
        CFG_AVOID_GAIN    = 3'd1,
        CFG_RTT_WEIGHT    = 3'd2,
        CFG_START_WINDOW  = 3'd3,
        CFG_START_TO_SEC  = 3'd4,
        CFG_START_TO_USEC = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_CREATE  = 2'd1,
        KIND_WAIT    = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ACK,
        OP_CREATE,
        OP_T_MUL,
        OP_W_MUL,
        OP_SUM,
        OP_DBL,
        OP_DIV_T,
        OP_SET_TO,
        OP_G_MUL,
        OP_DIV_G,
        OP_G_APPLY,
        OP_D_MUL,
        OP_DIV_D,
        OP_D_APPLY
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACK,
        ST_CREATE,
        ST_T_MUL,
        ST_W_MUL,
        ST_SUM,
        ST_DBL,
        ST_T_START,
        ST_T_WAIT,
        ST_SET_TO,
        ST_G_MUL,
        ST_G_START,
        ST_G_WAIT,
        ST_G_APPLY,
        ST_D_MUL,
        ST_D_START,
        ST_D_WAIT,
        ST_D_APPLY,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic need_rtt;
        logic win_gt1;
        logic div_done;
    } status_t;

endpackage

[design/acwc_ctrl.sv]
// acwc_ctrl: sequencing state machine and result handshake
// depends on acwc_pkg
module acwc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  acwc_pkg::status_t status,
    output acwc_pkg::cmd_t    cmd
);

    acwc_pkg::state_t state_reg, state_next;
    logic valid_reg, valid_next;
    logic slot_free;

    assign slot_free = !valid_reg || m_ready;
    assign m_valid   = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acwc_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = acwc_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        s_ready      = 1'b0;
        valid_next   = valid_reg && !m_ready;
        case (state_reg)
            acwc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = acwc_pkg::OP_LATCH;
                    state_next = acwc_pkg::ST_ACK;
                end
            end
            acwc_pkg::ST_ACK: begin
                case (status.kind)
                    acwc_pkg::KIND_ACK: begin
                        cmd.op = acwc_pkg::OP_ACK;
                        state_next = status.need_rtt ? acwc_pkg::ST_T_MUL : acwc_pkg::ST_OUT;
                    end
                    acwc_pkg::KIND_CREATE: state_next = acwc_pkg::ST_CREATE;
                    default: state_next = acwc_pkg::ST_G_MUL;
                endcase
            end
            acwc_pkg::ST_CREATE: begin
                cmd.op = acwc_pkg::OP_CREATE;
                state_next = acwc_pkg::ST_OUT;
            end
            acwc_pkg::ST_T_MUL: begin
                cmd.op = acwc_pkg::OP_T_MUL;
                state_next = (status.kind == acwc_pkg::KIND_TIMEOUT) ?
                             acwc_pkg::ST_DBL : acwc_pkg::ST_W_MUL;
            end
            acwc_pkg::ST_W_MUL: begin
                cmd.op = acwc_pkg::OP_W_MUL;
                state_next = acwc_pkg::ST_SUM;
            end
            acwc_pkg::ST_SUM: begin
                cmd.op = acwc_pkg::OP_SUM;
                state_next = acwc_pkg::ST_T_START;
            end
            acwc_pkg::ST_DBL: begin
                cmd.op = acwc_pkg::OP_DBL;
                state_next = acwc_pkg::ST_T_START;
            end
            acwc_pkg::ST_T_START: begin
                cmd.op = acwc_pkg::OP_DIV_T;
                state_next = acwc_pkg::ST_T_WAIT;
            end
            acwc_pkg::ST_T_WAIT: begin
                if (status.div_done) state_next = acwc_pkg::ST_SET_TO;
            end
            acwc_pkg::ST_SET_TO: begin
                cmd.op = acwc_pkg::OP_SET_TO;
                state_next = acwc_pkg::ST_OUT;
            end
            acwc_pkg::ST_G_MUL: begin
                cmd.op = acwc_pkg::OP_G_MUL;
                state_next = acwc_pkg::ST_G_START;
            end
            acwc_pkg::ST_G_START: begin
                cmd.op = acwc_pkg::OP_DIV_G;
                state_next = acwc_pkg::ST_G_WAIT;
            end
            acwc_pkg::ST_G_WAIT: begin
                if (status.div_done) state_next = acwc_pkg::ST_G_APPLY;
            end
            acwc_pkg::ST_G_APPLY: begin
                cmd.op = acwc_pkg::OP_G_APPLY;
                state_next = (status.kind == acwc_pkg::KIND_TIMEOUT) ?
                             acwc_pkg::ST_D_MUL : acwc_pkg::ST_OUT;
            end
            acwc_pkg::ST_D_MUL: begin
                cmd.op = acwc_pkg::OP_D_MUL;
                state_next = status.win_gt1 ? acwc_pkg::ST_D_START : acwc_pkg::ST_T_MUL;
            end
            acwc_pkg::ST_D_START: begin
                cmd.op = acwc_pkg::OP_DIV_D;
                state_next = acwc_pkg::ST_D_WAIT;
            end
            acwc_pkg::ST_D_WAIT: begin
                if (status.div_done) state_next = acwc_pkg::ST_D_APPLY;
            end
            acwc_pkg::ST_D_APPLY: begin
                cmd.op = acwc_pkg::OP_D_APPLY;
                state_next = acwc_pkg::ST_T_MUL;
            end
            acwc_pkg::ST_OUT: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    valid_next = 1'b1;
                    state_next = acwc_pkg::ST_IDLE;
                end
            end
            default: state_next = acwc_pkg::ST_IDLE;
        endcase
    end

endmodule

[design/acwc_datapath.sv]
// acwc_datapath: window, sequence and timeout state, multipliers, shared divider
// depends on acwc_pkg
module acwc_datapath #(
    parameter int SEQ_BITS = acwc_pkg::SEQ_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  acwc_pkg::cmd_t                    cmd,
    output acwc_pkg::status_t                 status,
    input  logic [1:0]                        s_kind,
    input  logic [15:0]                       s_ack_seq,
    input  logic                              s_ack_good,
    input  logic [31:0]                       s_rtt_us,
    input  logic                              cfg_we,
    input  logic [acwc_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [acwc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                              m_create_granted,
    output logic [15:0]                       m_granted_seq,
    output logic [15:0]                       m_window_now,
    output logic [15:0]                       m_last_acked,
    output logic [15:0]                       m_send_upto,
    output logic                              m_fast_retx,
    output logic                              m_round_over,
    output logic                              m_all_acked,
    output logic [11:0]                       m_timeout_sec_now,
    output logic [19:0]                       m_timeout_usec_now
);

    localparam int LW = (SEQ_BITS > 16) ? SEQ_BITS : 16;
    localparam int DW = acwc_pkg::DIVD_W;
    localparam int VW = acwc_pkg::DIVS_W;
    // one million is 64 times 15625; reciprocal of 15625 scaled by 2^41
    localparam logic [27:0] USEC_RCP = 28'd140737489;

    // configuration
    logic [3:0]  dup_thr_reg;
    logic [15:0] gain_reg;
    logic [8:0]  weight_reg;
    logic [11:0] start_sec_reg;
    logic [19:0] start_usec_reg;

    // protocol state
    logic [SEQ_BITS-1:0] acked_reg, next_seq_reg;
    logic [3:0]  dup_reg;
    logic        fast_reg, slow_reg;
    logic [15:0] window_reg, decdiv_reg, acks_reg;
    logic [11:0] to_sec_reg;
    logic [19:0] to_usec_reg;

    // item
    acwc_pkg::kind_t     kind_reg;
    logic [SEQ_BITS-1:0] aseq_reg;
    logic                good_reg;
    logic [31:0]         rtt_reg;
    logic                granted_reg, round_reg;
    logic [SEQ_BITS-1:0] gseq_reg;

    // arithmetic
    logic [31:0] tot_reg;
    logic [40:0] pa_reg, pb_reg;
    logic [DW-1:0] num_reg;
    logic [31:0] prod_reg;
    logic [54:0] rcp_reg;
    logic [1:0]  tstep_reg;

    // divider
    logic [DW-1:0]     quo_reg;
    logic [VW-1:0]     rem_reg, dvs_reg;
    logic [acwc_pkg::DIVC_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [VW:0]       shifted, trial;

    // combinational helpers
    logic [SEQ_BITS-1:0] diff, pend, lim_s, upto, inflight;
    logic                half_ok, diff0, need_rtt;
    logic [3:0]          thr, dc;
    logic [8:0]          wsat;
    logic [19:0]         usec_clamp;
    logic [41:0]         wsum;
    logic [24:0]         gwin;

    assign diff     = aseq_reg - acked_reg;
    assign diff0    = (diff == '0);
    assign half_ok  = !diff[SEQ_BITS-1];
    assign need_rtt = (fast_reg && diff0) || (good_reg && half_ok);
    assign thr      = (dup_thr_reg == 4'd0) ? 4'd1 : dup_thr_reg;
    assign dc       = diff0 ? ((dup_reg < 4'd15) ? dup_reg + 4'd1 : dup_reg) : 4'd0;
    assign wsat     = (weight_reg > acwc_pkg::WEIGHT_ONE) ? acwc_pkg::WEIGHT_ONE : weight_reg;
    assign usec_clamp = (cfg_wdata > acwc_pkg::USEC_MAX) ? acwc_pkg::USEC_MAX : cfg_wdata;
    assign wsum     = {1'b0, pa_reg} + {1'b0, pb_reg};
    assign gwin     = {9'd0, window_reg} + {8'd0, quo_reg[16:0]};
    assign inflight = next_seq_reg - acked_reg;
    assign pend     = next_seq_reg - SEQ_BITS'(1) - acked_reg;
    assign lim_s    = (LW'(pend) < LW'(window_reg)) ? pend : SEQ_BITS'(window_reg);
    assign upto     = acked_reg + lim_s;

    assign shifted  = {rem_reg, quo_reg[DW-1]};
    assign trial    = shifted - {1'b0, dvs_reg};

    assign status.kind     = kind_reg;
    assign status.need_rtt = need_rtt;
    assign status.win_gt1  = (window_reg > 16'd1);
    assign status.div_done = !busy_reg && (tstep_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dup_thr_reg    <= acwc_pkg::DUP_THR_RST;
            gain_reg       <= acwc_pkg::GAIN_RST;
            weight_reg     <= acwc_pkg::WEIGHT_RST;
            start_sec_reg  <= acwc_pkg::TO_SEC_RST;
            start_usec_reg <= acwc_pkg::TO_USEC_RST;
            acked_reg      <= '0;
            next_seq_reg   <= SEQ_BITS'(1);
            dup_reg        <= 4'd0;
            fast_reg       <= 1'b0;
            slow_reg       <= 1'b1;
            window_reg     <= acwc_pkg::WINDOW_RST;
            decdiv_reg     <= 16'd1;
            acks_reg       <= 16'd0;
            to_sec_reg     <= acwc_pkg::TO_SEC_RST;
            to_usec_reg    <= acwc_pkg::TO_USEC_RST;
            kind_reg       <= acwc_pkg::KIND_ACK;
            granted_reg    <= 1'b0;
            round_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            tstep_reg      <= 2'd0;
        end else begin
            if (busy_reg) begin
                quo_reg <= {quo_reg[DW-2:0], !trial[VW]};
                rem_reg <= trial[VW] ? shifted[VW-1:0] : trial[VW-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == acwc_pkg::DIVC_W'(1)) busy_reg <= 1'b0;
            end
            // seconds from the reciprocal product, then the microsecond remainder
            if (tstep_reg == 2'd2) begin
                quo_reg   <= DW'(rcp_reg[54:41]);
                tstep_reg <= 2'd1;
            end else if (tstep_reg == 2'd1) begin
                rem_reg   <= VW'(num_reg - DW'(quo_reg[13:0]) * DW'(acwc_pkg::USEC_PER_SEC));
                tstep_reg <= 2'd0;
            end
            case (cmd.op)
                acwc_pkg::OP_LATCH: begin
                    kind_reg    <= acwc_pkg::kind_t'(s_kind);
                    aseq_reg    <= SEQ_BITS'(s_ack_seq);
                    good_reg    <= s_ack_good;
                    rtt_reg     <= s_rtt_us;
                    granted_reg <= 1'b0;
                    round_reg   <= 1'b0;
                    gseq_reg    <= '0;
                end
                acwc_pkg::OP_ACK: begin
                    if (!(fast_reg && diff0) && good_reg && half_ok) begin
                        if (!diff0) begin
                            if (slow_reg) begin
                                if (window_reg != 16'hFFFF) window_reg <= window_reg + 16'd1;
                            end else if (acks_reg != 16'hFFFF) begin
                                acks_reg <= acks_reg + 16'd1;
                            end
                            fast_reg <= 1'b0;
                        end
                        if (dc >= thr) begin
                            fast_reg  <= 1'b1;
                            dup_reg   <= 4'd0;
                            slow_reg  <= 1'b0;
                            if (decdiv_reg != 16'hFFFF) decdiv_reg <= decdiv_reg + 16'd1;
                            round_reg <= 1'b1;
                        end else begin
                            dup_reg   <= dc;
                            acked_reg <= aseq_reg;
                            round_reg <= ((aseq_reg + SEQ_BITS'(1)) == next_seq_reg);
                        end
                    end
                end
                acwc_pkg::OP_CREATE: begin
                    if (LW'(inflight) <= LW'(window_reg)) begin
                        granted_reg  <= 1'b1;
                        gseq_reg     <= next_seq_reg;
                        next_seq_reg <= next_seq_reg + SEQ_BITS'(1);
                    end
                end
                acwc_pkg::OP_T_MUL: begin
                    tot_reg <= 32'(to_sec_reg * acwc_pkg::USEC_PER_SEC) + 32'(to_usec_reg);
                end
                acwc_pkg::OP_W_MUL: begin
                    pa_reg <= wsat * tot_reg;
                    pb_reg <= (acwc_pkg::WEIGHT_ONE - wsat) * rtt_reg;
                end
                acwc_pkg::OP_SUM: num_reg <= DW'(wsum >> 8);
                acwc_pkg::OP_DBL: num_reg <= {tot_reg, 1'b0};
                acwc_pkg::OP_DIV_T: begin
                    rcp_reg   <= num_reg[DW-1:6] * USEC_RCP;
                    tstep_reg <= 2'd2;
                end
                acwc_pkg::OP_SET_TO: begin
                    if (quo_reg > DW'(acwc_pkg::SEC_MAX)) begin
                        to_sec_reg  <= acwc_pkg::SEC_MAX;
                        to_usec_reg <= acwc_pkg::USEC_MAX;
                    end else begin
                        to_sec_reg  <= quo_reg[11:0];
                        to_usec_reg <= rem_reg[19:0];
                    end
                end
                acwc_pkg::OP_G_MUL: prod_reg <= gain_reg * acks_reg;
                acwc_pkg::OP_DIV_G: begin
                    quo_reg  <= DW'(prod_reg);
                    dvs_reg  <= {window_reg, 8'd0};
                    rem_reg  <= '0;
                    cnt_reg  <= acwc_pkg::DIVC_W'(DW);
                    busy_reg <= 1'b1;
                end
                acwc_pkg::OP_G_APPLY: begin
                    window_reg <= (quo_reg[DW-1:17] != '0 || gwin[24:16] != '0) ?
                                  16'hFFFF : gwin[15:0];
                    acks_reg   <= 16'd0;
                    if (kind_reg == acwc_pkg::KIND_TIMEOUT) slow_reg <= 1'b0;
                end
                acwc_pkg::OP_D_MUL: prod_reg <= window_reg * decdiv_reg;
                acwc_pkg::OP_DIV_D: begin
                    quo_reg  <= DW'(prod_reg);
                    dvs_reg  <= VW'({1'b0, decdiv_reg} + 17'd1);
                    rem_reg  <= '0;
                    cnt_reg  <= acwc_pkg::DIVC_W'(DW);
                    busy_reg <= 1'b1;
                end
                acwc_pkg::OP_D_APPLY: window_reg <= quo_reg[15:0];
                default: ;
            endcase
            if (cfg_we) begin
                case (acwc_pkg::cfg_idx_t'(cfg_addr))
                    acwc_pkg::CFG_DUP_THRESHOLD: dup_thr_reg <= cfg_wdata[3:0];
                    acwc_pkg::CFG_AVOID_GAIN:    gain_reg    <= cfg_wdata[15:0];
                    acwc_pkg::CFG_RTT_WEIGHT:    weight_reg  <= cfg_wdata[8:0];
                    acwc_pkg::CFG_START_WINDOW: begin
                        window_reg    <= (cfg_wdata[15:0] == 16'd0) ? 16'd1 : cfg_wdata[15:0];
                    end
                    acwc_pkg::CFG_START_TO_SEC: begin
                        start_sec_reg <= cfg_wdata[11:0];
                        to_sec_reg    <= cfg_wdata[11:0];
                        to_usec_reg   <= start_usec_reg;
                    end
                    acwc_pkg::CFG_START_TO_USEC: begin
                        start_usec_reg <= usec_clamp;
                        to_usec_reg    <= usec_clamp;
                        to_sec_reg     <= start_sec_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_create_granted   <= granted_reg;
            m_granted_seq      <= 16'(gseq_reg);
            m_window_now       <= window_reg;
            m_last_acked       <= 16'(acked_reg);
            m_send_upto        <= 16'(upto);
            m_fast_retx        <= fast_reg;
            m_round_over       <= round_reg;
            m_all_acked        <= ((acked_reg + SEQ_BITS'(1)) == next_seq_reg);
            m_timeout_sec_now  <= to_sec_reg;
            m_timeout_usec_now <= to_usec_reg;
        end
    end

endmodule

[design/ack_congestion_window_control_core.sv]
// ack congestion window controller, top level
// create and ack without sample need no division; ack with sample runs the timeout update,
// wait end the gain division, timeout the gain, decrease (skipped when the window is 1) and
// timeout steps; gain and decrease share the 33-step restoring divider
// throughput: one item at a time, the next accepted in the cycle after the result is registered
// reset: synchronous active-low aresetn restores control, configuration and window state; result outputs are not reset
module ack_congestion_window_control_core #(
    parameter int SEQ_BITS = acwc_pkg::SEQ_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_kind,
    input  logic [15:0]                     s_ack_seq,
    input  logic                            s_ack_good,
    input  logic [31:0]                     s_rtt_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_create_granted,
    output logic [15:0]                     m_granted_seq,
    output logic [15:0]                     m_window_now,
    output logic [15:0]                     m_last_acked,
    output logic [15:0]                     m_send_upto,
    output logic                            m_fast_retx,
    output logic                            m_round_over,
    output logic                            m_all_acked,
    output logic [11:0]                     m_timeout_sec_now,
    output logic [19:0]                     m_timeout_usec_now,
    input  logic                            cfg_we,
    input  logic [acwc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [acwc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    acwc_pkg::cmd_t    cmd;
    acwc_pkg::status_t status;

    acwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    acwc_datapath #(
        .SEQ_BITS (SEQ_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_kind             (s_kind),
        .s_ack_seq          (s_ack_seq),
        .s_ack_good         (s_ack_good),
        .s_rtt_us           (s_rtt_us),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .m_create_granted   (m_create_granted),
        .m_granted_seq      (m_granted_seq),
        .m_window_now       (m_window_now),
        .m_last_acked       (m_last_acked),
        .m_send_upto        (m_send_upto),
        .m_fast_retx        (m_fast_retx),
        .m_round_over       (m_round_over),
        .m_all_acked        (m_all_acked),
        .m_timeout_sec_now  (m_timeout_sec_now),
        .m_timeout_usec_now (m_timeout_usec_now)
    );

endmodule
